### sv/dfdr_pkg.sv
package dfdr_pkg;

  localparam int unsigned MaxFrameBytesDefault = 512;

  localparam logic [7:0] CharDle = 8'h10;
  localparam logic [7:0] CharStx = 8'h02;
  localparam logic [7:0] CharEtx = 8'h03;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_OVERSIZE   = 3'd1,
    ERR_ABORTED    = 3'd2,
    ERR_BAD_ESCAPE = 3'd3,
    ERR_SHORT      = 3'd4,
    ERR_INCOMPLETE = 3'd5,
    ERR_CHECKSUM   = 3'd6
  } err_e;

  typedef struct packed {
    logic        vld;
    kind_e       kind;
    logic [7:0]  payload;
    logic [7:0]  id;
    logic [7:0]  len;
    err_e        err;
    logic [31:0] good;
    logic [31:0] dropped;
  } res_t;

endpackage

### sv/dfdr_core.sv
module dfdr_core #(
  parameter int unsigned MAX_FRAME_BYTES = dfdr_pkg::MaxFrameBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output dfdr_pkg::res_t    res_o
);
  import dfdr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_GOT_DLE  = 2'd1,
    ST_IN_FRAME = 2'd2,
    ST_IN_DLE   = 2'd3
  } state_e;

  localparam logic [9:0] MaxCnt = 10'(MAX_FRAME_BYTES);

  state_e      state_q, state_d;
  logic [9:0]  cnt_q, cnt_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  sum_q, sum_d;
  logic [31:0] good_q, good_d;
  logic [31:0] drop_q, drop_d;
  res_t        res;

  logic        full;
  logic        st_sum_en;
  logic        st_emit;
  logic [10:0] cnt_ext;
  logic [10:0] len_p2;
  logic [10:0] len_p3;

  assign full    = (cnt_q >= MaxCnt);
  assign cnt_ext = {1'b0, cnt_q};
  assign len_p2  = 11'd2 + {3'b000, len_q};
  assign len_p3  = 11'd3 + {3'b000, len_q};
  // Only id, length, data and checksum enter the sum; trailing bytes do not.
  assign st_sum_en = (cnt_q < 10'd2) || (cnt_ext <= len_p2);
  assign st_emit   = (cnt_q >= 10'd2) && (cnt_ext < len_p2);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    id_d    = id_q;
    len_d   = len_q;
    sum_d   = sum_q;
    good_d  = good_q;
    drop_d  = drop_q;
    res         = '0;
    res.kind    = KIND_PAYLOAD;
    res.err     = ERR_NONE;

    unique case (state_q)
      ST_IDLE: begin
        if (byte_i == CharDle) state_d = ST_GOT_DLE;
      end
      ST_GOT_DLE: begin
        if (byte_i == CharStx) begin
          cnt_d   = '0;
          id_d    = '0;
          len_d   = '0;
          sum_d   = '0;
          state_d = ST_IN_FRAME;
        end else if (byte_i != CharDle) begin
          state_d = ST_IDLE;
        end
      end
      ST_IN_FRAME: begin
        if (byte_i == CharDle) begin
          state_d = ST_IN_DLE;
        end else if (!full) begin
          if (cnt_q == 10'd0) id_d = byte_i;
          if (cnt_q == 10'd1) len_d = byte_i;
          if (st_sum_en) sum_d = sum_q + byte_i;
          if (st_emit) begin
            res.vld     = 1'b1;
            res.payload = byte_i;
          end
          cnt_d = cnt_q + 10'd1;
        end else begin
          drop_d   = drop_q + 32'd1;
          cnt_d    = '0;
          id_d     = '0;
          len_d    = '0;
          sum_d    = '0;
          res.vld  = 1'b1;
          res.kind = KIND_ERROR;
          res.err  = ERR_OVERSIZE;
          state_d  = ST_IDLE;
        end
      end
      ST_IN_DLE: begin
        if (byte_i == CharEtx) begin
          cnt_d   = '0;
          id_d    = '0;
          len_d   = '0;
          sum_d   = '0;
          state_d = ST_IDLE;
          if (cnt_q != 10'd0) begin
            res.vld = 1'b1;
            if (cnt_q < 10'd3) begin
              res.kind = KIND_ERROR;
              res.err  = ERR_SHORT;
            end else if (cnt_ext < len_p3) begin
              res.kind = KIND_ERROR;
              res.err  = ERR_INCOMPLETE;
            end else if (sum_q != 8'd0) begin
              res.kind = KIND_ERROR;
              res.err  = ERR_CHECKSUM;
            end else begin
              res.kind = KIND_GOOD;
              res.id   = id_q;
              res.len  = len_q;
            end
            if (res.kind == KIND_GOOD) good_d = good_q + 32'd1;
            else                       drop_d = drop_q + 32'd1;
          end
        end else if (byte_i == CharDle) begin
          // An escaped DLE is a literal data byte; when full it is dropped silently.
          if (!full) begin
            if (cnt_q == 10'd0) id_d = byte_i;
            if (cnt_q == 10'd1) len_d = byte_i;
            if (st_sum_en) sum_d = sum_q + byte_i;
            if (st_emit) begin
              res.vld     = 1'b1;
              res.payload = byte_i;
            end
            cnt_d = cnt_q + 10'd1;
          end
          state_d = ST_IN_FRAME;
        end else begin
          drop_d   = drop_q + 32'd1;
          cnt_d    = '0;
          id_d     = '0;
          len_d    = '0;
          sum_d    = '0;
          res.vld  = 1'b1;
          res.kind = KIND_ERROR;
          if (byte_i == CharStx) begin
            res.err = ERR_ABORTED;
            state_d = ST_IN_FRAME;
          end else begin
            res.err = ERR_BAD_ESCAPE;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    res.good    = good_d;
    res.dropped = drop_d;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      id_q    <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      good_q  <= '0;
      drop_q  <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      id_q    <= id_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      good_q  <= good_d;
      drop_q  <= drop_d;
    end
  end

endmodule

### sv/dle_frame_datagram_receiver.sv
// Channel  Handshake                     Fields
// in       in_valid_i / in_stall_o       rx_byte_i
// out      out_valid_o / out_stall_i     kind_o, payload_byte_o, datagram_id_o,
//                                        datagram_length_o, error_code_o,
//                                        good_count_o, dropped_count_o
//
// One byte per cycle sustained while no untaken result is held under out_stall_i. An accepted
// byte waits in the input register; its framing state update and result then go from there
// into the output register, which presents the result. Many bytes give no result.
// rst_ni clears the frame state and both frame counters.
// in_stall_o rises only while a byte is held and the output register holds an untaken
// transaction under out_stall_i.
module dle_frame_datagram_receiver #(
  parameter int unsigned MAX_FRAME_BYTES = dfdr_pkg::MaxFrameBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  datagram_id_o,
  output logic [7:0]  datagram_length_o,
  output logic [2:0]  error_code_o,
  output logic [31:0] good_count_o,
  output logic [31:0] dropped_count_o
);
  import dfdr_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       step;
  logic       in_load;
  res_t       res;
  res_t       out_q;
  logic       out_vld_q;

  // The held byte is processed once the output register can take its result.
  assign step       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;
  assign in_load    = !in_vld_q || step;

  dfdr_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_load) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) in_byte_q <= rx_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || !out_stall_i) begin
      out_vld_q <= step && res.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.vld) out_q <= res;
  end

  assign out_valid_o       = out_vld_q;
  assign kind_o            = out_q.kind;
  assign payload_byte_o    = out_q.payload;
  assign datagram_id_o     = out_q.id;
  assign datagram_length_o = out_q.len;
  assign error_code_o      = out_q.err;
  assign good_count_o      = out_q.good;
  assign dropped_count_o   = out_q.dropped;

endmodule
